/* sv/http_request_framer_unit_assert.svh */
// assertion macros for the http request framer
// included by files that carry concurrent checks; no other dependencies
`ifndef HTTP_REQUEST_FRAMER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_FRAMER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// combinational or overlapped implication, checked out of reset
`define HRF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition in one cycle implies a property in the next
`define HRF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HRF_ASSERT(lbl, clk, rst_n, prop, msg)
`define HRF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* sv/hrf_pkg.sv */
// shared types, codes and character helpers for the http request framer
// no dependencies
package hrf_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int LEN_W          = 32;
    localparam int HDR_LIM_W      = 21;
    localparam int BODY_LIM_W     = 33;
    localparam int CFG_DATA_W     = 33;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;

    localparam logic [3:0]  NAME_LEN     = 4'd14;
    localparam logic [23:0] TERM_CRLFCR  = 24'h0D0A0D;

    localparam logic CFG_MAX_HEADER = 1'b0;
    localparam logic CFG_MAX_BODY   = 1'b1;

    typedef enum logic [1:0] {
        PH_REQLINE,
        PH_HEADERS,
        PH_BODY,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        LM_LEAD,
        LM_NAME,
        LM_TRAIL,
        LM_SKIP,
        LM_VLEAD,
        LM_VSIGN,
        LM_VDIGIT,
        LM_VTRAIL
    } t_line_mode;

    typedef enum logic [2:0] {
        ST_NEED_MORE,
        ST_COMPLETE,
        ST_HDR_LARGE,
        ST_BODY_LARGE,
        ST_IGNORED
    } t_status;

    typedef struct packed {
        t_line_mode       mode;
        logic [3:0]       name_pos;
        logic [LEN_W-1:0] value;
        logic             found;
        logic             neg;
    } t_line_state;

    typedef struct packed {
        logic    hdr_over;
        t_status status;
    } t_verdict;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_req_word;

    typedef struct packed {
        t_status          status;
        logic [LEN_W-1:0] header_length;
        logic [LEN_W-1:0] content_length;
    } t_res_word;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) || (c == 8'h85) || (c == 8'hA0);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // lower-case "content-length"
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h63;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h6C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* sv/hrf_stream_if.sv */
// valid/ready stream channel carrying one word of type T_WORD
// no dependencies; the word type is given at instantiation
interface hrf_stream_if #(
    parameter type T_WORD = logic
);
    logic  valid;
    logic  ready;
    T_WORD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/hrf_line_parser.sv */
// content-length header line scanner: next line state for one header byte
// depends on hrf_pkg
module hrf_line_parser
    import hrf_pkg::*;
(
    input  logic [7:0]  i_byte,
    input  t_line_state i_state,
    output t_line_state o_state
);

    logic [LEN_W+3:0] prod;
    logic [7:0]       digit;
    logic             is_digit;
    logic             ws;
    logic [7:0]       lc;

    assign digit    = i_byte - CHR_0;
    assign is_digit = (i_byte >= CHR_0) && (i_byte <= CHR_9);
    assign ws       = is_ws(i_byte);
    assign lc       = to_lower(i_byte);
    // value * 10 + digit, at most 36 bits
    assign prod = ({4'b0, i_state.value} << 3) + ({4'b0, i_state.value} << 1)
                + (LEN_W+4)'(digit[3:0]);

    always_comb begin
        o_state = i_state;
        if (i_byte == CHR_LF) begin
            if (i_state.mode == LM_VDIGIT || i_state.mode == LM_VTRAIL) begin
                o_state.found = 1'b1;
                o_state.value = i_state.neg ? '0 : i_state.value;
            end else if (i_state.mode == LM_VLEAD || i_state.mode == LM_VSIGN) begin
                o_state.found = 1'b1;
                o_state.value = '0;
            end
            o_state.mode     = LM_LEAD;
            o_state.name_pos = '0;
        end else if (!i_state.found) begin
            case (i_state.mode)
                LM_LEAD: begin
                    if (!ws) begin
                        if (lc == name_char(4'd0)) begin
                            o_state.mode     = LM_NAME;
                            o_state.name_pos = 4'd1;
                        end else begin
                            o_state.mode = LM_SKIP;
                        end
                    end
                end
                LM_NAME: begin
                    if (i_state.name_pos < NAME_LEN && lc == name_char(i_state.name_pos)) begin
                        o_state.name_pos = i_state.name_pos + 4'd1;
                    end else if (i_state.name_pos >= NAME_LEN && ws) begin
                        o_state.mode = LM_TRAIL;
                    end else if (i_state.name_pos >= NAME_LEN && i_byte == CHR_COLON) begin
                        o_state.mode  = LM_VLEAD;
                        o_state.value = '0;
                    end else begin
                        o_state.mode = LM_SKIP;
                    end
                end
                LM_TRAIL: begin
                    if (i_byte == CHR_COLON) begin
                        o_state.mode  = LM_VLEAD;
                        o_state.value = '0;
                    end else if (!ws) begin
                        o_state.mode = LM_SKIP;
                    end
                end
                LM_VLEAD, LM_VSIGN, LM_VDIGIT: begin
                    if (is_digit) begin
                        if (prod > (LEN_W+4)'(LEN_MAX)) begin
                            // over range counts as zero
                            o_state.found = 1'b1;
                            o_state.value = '0;
                            o_state.mode  = LM_SKIP;
                        end else begin
                            o_state.value = prod[LEN_W-1:0];
                            o_state.mode  = LM_VDIGIT;
                        end
                    end else if (i_state.mode == LM_VLEAD && ws) begin
                        o_state.mode = LM_VLEAD;
                    end else if (i_state.mode == LM_VLEAD &&
                                 (i_byte == CHR_PLUS || i_byte == CHR_MINUS)) begin
                        if (i_byte == CHR_MINUS) begin
                            o_state.neg = 1'b1;
                        end
                        o_state.mode = LM_VSIGN;
                    end else if (i_state.mode == LM_VDIGIT && ws) begin
                        o_state.mode = LM_VTRAIL;
                    end else begin
                        o_state.found = 1'b1;
                        o_state.value = '0;
                        o_state.mode  = LM_SKIP;
                    end
                end
                LM_VTRAIL: begin
                    if (!ws) begin
                        o_state.found = 1'b1;
                        o_state.value = '0;
                        o_state.mode  = LM_SKIP;
                    end
                end
                default: begin
                    o_state.mode = i_state.mode;
                end
            endcase
        end
    end

endmodule

/* sv/hrf_limit_judge.sv */
// size limit and completeness check for the header and body counts
// depends on hrf_pkg
module hrf_limit_judge
    import hrf_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic signed [HDR_LIM_W-1:0]  i_max_header,
    input  logic signed [BODY_LIM_W-1:0] i_max_body,
    input  logic [COUNT_BITS-1:0]        i_header_count,
    input  logic [COUNT_BITS-1:0]        i_body_count,
    input  logic [LEN_W-1:0]             i_content_length,
    output t_verdict                     o_verdict
);

    localparam int JW = (COUNT_BITS > BODY_LIM_W) ? COUNT_BITS : BODY_LIM_W;

    logic [JW-1:0] hc;
    logic [JW-1:0] bc;
    logic [JW-1:0] cl;
    logic [JW-1:0] mh;
    logic [JW-1:0] mb;
    logic          hdr_on;
    logic          body_on;

    assign hc      = JW'(i_header_count);
    assign bc      = JW'(i_body_count);
    assign cl      = JW'(i_content_length);
    assign mh      = JW'(i_max_header[HDR_LIM_W-2:0]);
    assign mb      = JW'(i_max_body[BODY_LIM_W-2:0]);
    // a negative limit switches its check off
    assign hdr_on  = !i_max_header[HDR_LIM_W-1];
    assign body_on = !i_max_body[BODY_LIM_W-1];

    always_comb begin
        o_verdict.hdr_over = hdr_on && (hc > mh);
        if (o_verdict.hdr_over) begin
            o_verdict.status = ST_HDR_LARGE;
        end else if (body_on && ((cl > mb) || (bc > mb))) begin
            o_verdict.status = ST_BODY_LARGE;
        end else if (bc >= cl) begin
            o_verdict.status = ST_COMPLETE;
        end else begin
            o_verdict.status = ST_NEED_MORE;
        end
    end

endmodule

/* sv/http_request_framer_unit.sv */
// http request framer top: input register, framing state, result register
// depends on hrf_pkg, hrf_stream_if, hrf_line_parser, hrf_limit_judge
//
//  port      dir   word                                         use
//  i_req     sink  data_byte[8], first_byte[1]                  request bytes
//  o_res     src   status[3], header_length[32], content_length[32]  one per byte
//  i_cfg_*   in    we, index[1], data[33]                       limit registers
//
// one byte per cycle sustained while results are taken; a result becomes valid after its byte
// has waited in the input register and the framing logic has loaded the result register
// synchronous reset clears framing state and sets both limits to -1 (disabled)
// when the result register is full and not taken the input register holds and ready drops
`include "http_request_framer_unit_assert.svh"
module http_request_framer_unit
    import hrf_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hrf_stream_if.sink            i_req,
    hrf_stream_if.source          o_res
);

    localparam int HW = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    localparam t_line_state LINE_RESET = '{
        mode: LM_LEAD, name_pos: '0, value: '0, found: 1'b0, neg: 1'b0
    };

    // configuration
    logic signed [HDR_LIM_W-1:0]  r_max_header;
    logic signed [BODY_LIM_W-1:0] r_max_body;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;

    // framing state
    t_phase          r_phase, n_phase;
    logic [23:0]     r_recent, n_recent;
    logic [COUNT_BITS-1:0] r_header_count, n_header_count;
    logic [COUNT_BITS-1:0] r_body_count, n_body_count;
    t_line_state     r_line, n_line;
    logic            r_found_end, n_found_end;

    // result register
    logic             r_out_valid;
    t_status          r_out_status, n_out_status;
    logic [LEN_W-1:0] r_out_hlen, n_out_hlen;
    logic [LEN_W-1:0] r_out_clen, n_out_clen;

    logic adv;

    // state seen by this byte, after an optional restart
    t_phase                cur_phase;
    logic [23:0]           cur_recent;
    logic [COUNT_BITS-1:0] cur_hc;
    logic [COUNT_BITS-1:0] cur_bc;
    t_line_state           cur_line;
    logic                  cur_found_end;

    logic [COUNT_BITS-1:0] hc_inc;
    logic [COUNT_BITS-1:0] bc_inc;
    t_line_state           parsed;
    logic                  term;
    logic [COUNT_BITS-1:0] j_hc;
    logic [COUNT_BITS-1:0] j_bc;
    logic [LEN_W-1:0]      j_cl;
    t_verdict              verdict;
    logic                  found;
    logic [HW-1:0]         hc_ext;

    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || adv;

    assign o_res.valid               = r_out_valid;
    assign o_res.data.status         = r_out_status;
    assign o_res.data.header_length  = r_out_hlen;
    assign o_res.data.content_length = r_out_clen;

    assign cur_phase     = r_in_first ? PH_REQLINE : r_phase;
    assign cur_recent    = r_in_first ? 24'h0 : r_recent;
    assign cur_hc        = r_in_first ? '0 : r_header_count;
    assign cur_bc        = r_in_first ? '0 : r_body_count;
    assign cur_line      = r_in_first ? LINE_RESET : r_line;
    assign cur_found_end = r_in_first ? 1'b0 : r_found_end;

    assign hc_inc = (cur_hc == '1) ? cur_hc : cur_hc + COUNT_BITS'(1);
    assign bc_inc = (cur_bc == '1) ? cur_bc : cur_bc + COUNT_BITS'(1);

    // earliest lflf or crlfcrlf, judged at its last byte
    assign term = (r_in_byte == CHR_LF) &&
                  ((cur_recent[7:0] == CHR_LF) || (cur_recent == TERM_CRLFCR));

    hrf_line_parser u_parser (
        .i_byte  (r_in_byte),
        .i_state (cur_line),
        .o_state (parsed)
    );

    assign j_hc = (cur_phase == PH_BODY) ? cur_hc : hc_inc;
    assign j_bc = (cur_phase == PH_BODY) ? bc_inc : '0;
    assign j_cl = (cur_phase == PH_BODY) ? cur_line.value :
                  (parsed.found ? parsed.value : '0);

    hrf_limit_judge #(
        .COUNT_BITS (COUNT_BITS)
    ) u_judge (
        .i_max_header     (r_max_header),
        .i_max_body       (r_max_body),
        .i_header_count   (j_hc),
        .i_body_count     (j_bc),
        .i_content_length (j_cl),
        .o_verdict        (verdict)
    );

    always_comb begin
        n_phase        = cur_phase;
        n_recent       = cur_recent;
        n_header_count = cur_hc;
        n_body_count   = cur_bc;
        n_line         = cur_line;
        n_found_end    = cur_found_end;
        n_out_status   = ST_NEED_MORE;
        found          = 1'b0;
        case (cur_phase)
            PH_DONE: begin
                n_out_status = ST_IGNORED;
                found        = cur_found_end;
            end
            PH_BODY: begin
                n_body_count = bc_inc;
                n_out_status = verdict.status;
                found        = 1'b1;
            end
            PH_REQLINE, PH_HEADERS: begin
                n_header_count = hc_inc;
                if (cur_phase == PH_REQLINE) begin
                    if (r_in_byte == CHR_LF) begin
                        n_phase = PH_HEADERS;
                    end
                end else begin
                    n_line = parsed;
                end
                n_recent = {cur_recent[15:0], r_in_byte};
                if (term) begin
                    if (!n_line.found) begin
                        n_line.value = '0;
                    end
                    n_phase      = PH_BODY;
                    n_body_count = '0;
                    n_out_status = verdict.status;
                    found        = 1'b1;
                end else if (verdict.hdr_over) begin
                    n_out_status = ST_HDR_LARGE;
                end
            end
            default: begin
                n_out_status = ST_IGNORED;
            end
        endcase
        // a final status closes the request
        if (cur_phase != PH_DONE &&
            (n_out_status == ST_COMPLETE || n_out_status == ST_HDR_LARGE ||
             n_out_status == ST_BODY_LARGE)) begin
            n_phase = PH_DONE;
            if (found) begin
                n_found_end = 1'b1;
            end
        end
    end

    assign hc_ext     = HW'(n_header_count);
    assign n_out_hlen = found ? hc_ext[LEN_W-1:0] : '0;
    assign n_out_clen = found ? n_line.value : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_header <= '1;
            r_max_body   <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_HEADER: r_max_header <= i_cfg_data[HDR_LIM_W-1:0];
                CFG_MAX_BODY:   r_max_body   <= i_cfg_data[BODY_LIM_W-1:0];
                default:        r_max_body   <= r_max_body;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_byte  <= i_req.data.data_byte;
            r_in_first <= i_req.data.first_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_REQLINE;
            r_recent       <= 24'h0;
            r_header_count <= '0;
            r_body_count   <= '0;
            r_line         <= LINE_RESET;
            r_found_end    <= 1'b0;
        end else if (adv) begin
            r_phase        <= n_phase;
            r_recent       <= n_recent;
            r_header_count <= n_header_count;
            r_body_count   <= n_body_count;
            r_line         <= n_line;
            r_found_end    <= n_found_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_status <= n_out_status;
            r_out_hlen   <= n_out_hlen;
            r_out_clen   <= n_out_clen;
        end
    end

    `HRF_ASSERT_NEXT(a_adv_fills_result, i_clk, i_rst_n, adv, r_out_valid, "result register not loaded")
    `HRF_ASSERT_NEXT(a_done_ignores, i_clk, i_rst_n, adv && !r_in_first && r_phase == PH_DONE, r_out_status == ST_IGNORED, "byte after final status not ignored")
    `HRF_ASSERT(a_found_end_only_done, i_clk, i_rst_n, r_phase != PH_DONE |-> !r_found_end, "header end flag set outside done")
    `HRF_ASSERT(a_no_body_in_header, i_clk, i_rst_n, (r_phase == PH_REQLINE || r_phase == PH_HEADERS) |-> r_body_count == '0, "body counted before header end")
    `HRF_ASSERT_NEXT(a_input_held, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid && $stable(r_in_byte), "stalled input byte lost")

endmodule
